FILE: hw/rtl/box_overlap_suppression_filter_core_defines.svh
// assertion macros shared by the box overlap suppression filter rtl
// no dependencies; included by files that carry concurrent checks
`ifndef BOX_OVERLAP_SUPPRESSION_FILTER_CORE_DEFINES_SVH
`define BOX_OVERLAP_SUPPRESSION_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define BOFS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bofs check failed");

// next-cycle implication check
`define BOFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bofs check failed");

`else

`define BOFS_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define BOFS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/bofs_pkg.sv
// shared types, constants and helpers for the box overlap suppression filter
// no dependencies
package bofs_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int COORD_BITS  = 16;
   localparam int FIELD_BITS  = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int THR_W       = 16;
   localparam int AREA_W      = 2 * FIELD_BITS;
   localparam int LIM_W       = AREA_W + THR_W;

   localparam logic [FIELD_BITS-1:0] COORD_MASK =
      FIELD_BITS'((33'd1 << COORD_BITS) - 33'd1);

   // request commands
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_APPEAR = 2'd1;
   localparam logic [1:0] CMD_MOTION = 2'd2;

   // register indexes
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic             ENABLE_RESET    = 1'b1;
   localparam logic             MODE_RESET      = 1'b1;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd19661;
   localparam logic             MODE_SUPPRESS   = 1'b1;

   typedef struct packed {
      logic [FIELD_BITS-1:0] y_max;
      logic [FIELD_BITS-1:0] x_max;
      logic [FIELD_BITS-1:0] y_min;
      logic [FIELD_BITS-1:0] x_min;
   } box_type;

   // status from the overlap pipeline to the sequencer
   typedef struct packed {
      logic busy;
      logic hit_valid;
      logic hit;
   } ovl_stat_type;

   function automatic logic [FIELD_BITS-1:0] span(input logic [FIELD_BITS-1:0] lo,
                                                   input logic [FIELD_BITS-1:0] hi);
      span = (hi > lo) ? (hi - lo) : '0;
   endfunction

   function automatic logic [FIELD_BITS-1:0] max_c(input logic [FIELD_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b);
      max_c = (a > b) ? a : b;
   endfunction

   function automatic logic [FIELD_BITS-1:0] min_c(input logic [FIELD_BITS-1:0] a,
                                                    input logic [FIELD_BITS-1:0] b);
      min_c = (a < b) ? a : b;
   endfunction

endpackage

FILE: hw/rtl/bofs_if.sv
// request and response channel interfaces of the box overlap suppression filter
// depends on bofs_pkg
interface bofs_req_if import bofs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            cmd;
   logic [FIELD_BITS-1:0] x_min;
   logic [FIELD_BITS-1:0] y_min;
   logic [FIELD_BITS-1:0] x_max;
   logic [FIELD_BITS-1:0] y_max;

   modport source (output valid, cmd, x_min, y_min, x_max, y_max, input ready);
   modport sink   (input valid, cmd, x_min, y_min, x_max, y_max, output ready);
endinterface

interface bofs_rsp_if import bofs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [FIELD_BITS-1:0] out_x_min;
   logic [FIELD_BITS-1:0] out_y_min;
   logic [FIELD_BITS-1:0] out_x_max;
   logic [FIELD_BITS-1:0] out_y_max;
   logic                  from_motion;
   logic                  table_overflow;

   modport source (output valid, out_x_min, out_y_min, out_x_max, out_y_max,
                   from_motion, table_overflow, input ready);
   modport sink   (input valid, out_x_min, out_y_min, out_x_max, out_y_max,
                   from_motion, table_overflow, output ready);
endinterface

FILE: hw/rtl/box_overlap_suppression_filter_core.sv
// top level of the box overlap suppression filter: sequencer, registers, output stage
// depends on bofs_pkg, bofs_if, bofs_box_ram, bofs_overlap_pipe and the defines header
//
// The block takes one request at a time. A start-frame request empties the table of
// preferred boxes and yields nothing. An appearance box is written into the table
// unless it is full, and is handed to the output stage when the block is enabled.
// A motion box in suppress mode is tested against every stored box (up to 64): the
// table memory is read at one entry per cycle through the registered read port into
// the four-stage overlap pipeline, and the box is dropped when any comparison hits.
// In merge mode or with an empty table a motion box goes straight to the output
// stage; when the block is disabled it yields nothing. The output register lets the
// next request be taken while a response still waits downstream. There is no
// clearing pass after reset; the table is tracked by its fill count.
`include "box_overlap_suppression_filter_core_defines.svh"

module box_overlap_suppression_filter_core import bofs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   bofs_req_if.sink              req_chan,
   bofs_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // sequencer states
   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   // control and status registers
   logic             enable_ff, enable_in;
   logic             mode_ff, mode_in;
   logic [THR_W-1:0] thr_ff, thr_in;

   // sequencer
   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             rd_valid_ff, rd_valid_in;
   logic             hit_ff, hit_in;

   // box being worked on and its response flags
   box_type          box_ff, box_in;
   logic             motion_ff, motion_in;
   logic             overflow_ff, overflow_in;

   // output stage
   logic             out_valid_ff, out_valid_in;
   box_type          out_box_ff, out_box_in;
   logic             out_motion_ff, out_motion_in;
   logic             out_overflow_ff, out_overflow_in;

   // memory and pipeline hookup
   logic             ram_wr_en, ram_rd_en;
   box_type          req_box, ram_rd_data;
   ovl_stat_type     pipe_stat;

   logic             req_fire, out_load, table_full, last_entry;

   // incoming coordinates, masked to the pixel range
   assign req_box.x_min = req_chan.x_min & COORD_MASK;
   assign req_box.y_min = req_chan.y_min & COORD_MASK;
   assign req_box.x_max = req_chan.x_max & COORD_MASK;
   assign req_box.y_max = req_chan.y_max & COORD_MASK;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign table_full     = (count_ff == CNT_W'(TABLE_DEPTH));
   assign last_entry     = ((CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff);
   // the output register is free when empty or being drained this cycle
   assign out_load       = (state_ff == ST_EMIT) && (!out_valid_ff || rsp_chan.ready);

   // register writes, unknown indexes are dropped
   always_comb begin
      enable_in = enable_ff;
      mode_in   = mode_ff;
      thr_in    = thr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ENABLE:    enable_in = csr_wr_data[0];
            CSR_MODE:      mode_in   = csr_wr_data[0];
            CSR_THRESHOLD: thr_in    = csr_wr_data[THR_W-1:0];
            default:       ;
         endcase
      end
   end

   // main sequencer
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      hit_in      = hit_ff | (pipe_stat.hit_valid & pipe_stat.hit);
      box_in      = box_ff;
      motion_in   = motion_ff;
      overflow_in = overflow_ff;
      ram_wr_en   = 1'b0;
      ram_rd_en   = 1'b0;
      rd_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               box_in = req_box;
               case (req_chan.cmd)
                  CMD_START: begin
                     count_in = '0;
                  end
                  CMD_APPEAR: begin
                     // stored regardless of enable and mode
                     ram_wr_en   = !table_full;
                     count_in    = table_full ? count_ff : count_ff + CNT_W'(1);
                     motion_in   = 1'b0;
                     overflow_in = table_full;
                     if (enable_ff) begin
                        state_in = ST_EMIT;
                     end
                  end
                  CMD_MOTION: begin
                     motion_in   = 1'b1;
                     overflow_in = 1'b0;
                     if (enable_ff) begin
                        if ((mode_ff == MODE_SUPPRESS) && (count_ff != '0)) begin
                           state_in    = ST_SCAN;
                           scan_idx_in = '0;
                           hit_in      = 1'b0;
                        end else begin
                           state_in = ST_EMIT;
                        end
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // one table entry per cycle into the overlap pipeline
            ram_rd_en   = 1'b1;
            rd_valid_in = 1'b1;
            if (last_entry) begin
               state_in = ST_DRAIN;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // wait for the last comparison to land in the hit flag
            if (!rd_valid_ff && !pipe_stat.busy) begin
               state_in = hit_ff ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output stage
   always_comb begin
      out_valid_in    = out_valid_ff;
      out_box_in      = out_box_ff;
      out_motion_in   = out_motion_ff;
      out_overflow_in = out_overflow_ff;
      if (out_load) begin
         out_valid_in    = 1'b1;
         out_box_in      = box_ff;
         out_motion_in   = motion_ff;
         out_overflow_in = overflow_ff;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= ENABLE_RESET;
         mode_ff      <= MODE_RESET;
         thr_ff       <= THRESHOLD_RESET;
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         hit_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         hit_ff       <= hit_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff     <= scan_idx_in;
      box_ff          <= box_in;
      motion_ff       <= motion_in;
      overflow_ff     <= overflow_in;
      out_box_ff      <= out_box_in;
      out_motion_ff   <= out_motion_in;
      out_overflow_ff <= out_overflow_in;
   end

   // preferred box table, appended at the fill count
   bofs_box_ram u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_box),
      .rd_en   (ram_rd_en),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rd_data)
   );

   // overlap test against the held motion box
   bofs_overlap_pipe u_overlap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .motion    (box_ff),
      .stored    (ram_rd_data),
      .threshold (thr_ff),
      .stat      (pipe_stat)
   );

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.out_x_min      = out_box_ff.x_min;
   assign rsp_chan.out_y_min      = out_box_ff.y_min;
   assign rsp_chan.out_x_max      = out_box_ff.x_max;
   assign rsp_chan.out_y_max      = out_box_ff.y_max;
   assign rsp_chan.from_motion    = out_motion_ff;
   assign rsp_chan.table_overflow = out_overflow_ff;

   // fill count never passes the table depth
   `BOFS_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(TABLE_DEPTH))
   // scan reads only filled entries
   `BOFS_ASSERT_IMPLIES(a_scan_in_range, clock, reset, state_ff == ST_SCAN, CNT_W'(scan_idx_ff) < count_ff)
   // no comparison left in flight once back in idle
   `BOFS_ASSERT_IMPLIES(a_idle_drained, clock, reset, state_ff == ST_IDLE, !pipe_stat.busy && !rd_valid_ff)
   // each table write grows the fill count by one
   `BOFS_ASSERT_NEXT(a_write_grows, clock, reset, ram_wr_en, count_ff == $past(count_ff) + CNT_W'(1))

endmodule

FILE: hw/rtl/bofs_box_ram.sv
// preferred box table: one write port, one registered read port
// depends on bofs_pkg
module bofs_box_ram import bofs_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_addr,
   input  box_type          wr_data,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_addr,
   output box_type          rd_data
);

   box_type mem_array [TABLE_DEPTH];
   box_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_array[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_array[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bofs_overlap_pipe.sv
// four-stage overlap test of the motion box against one stored box per cycle
// depends on bofs_pkg
module bofs_overlap_pipe import bofs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  box_type          motion,
   input  box_type          stored,
   input  logic [THR_W-1:0] threshold,
   output ovl_stat_type     stat
);

   // stage 1: spans
   logic                  v1_ff, v1_in;
   logic [FIELD_BITS-1:0] iw_ff, ih_ff, pw_ff, ph_ff, mw_ff, mh_ff;
   logic [FIELD_BITS-1:0] iw_in, ih_in, pw_in, ph_in, mw_in, mh_in;
   // stage 2: areas
   logic                  v2_ff, v2_in;
   logic [AREA_W-1:0]     inter2_ff, parea_ff, marea_ff;
   logic [AREA_W-1:0]     inter2_in, parea_in, marea_in;
   // stage 3: scaled limits
   logic                  v3_ff, v3_in;
   logic [AREA_W-1:0]     inter3_ff, inter3_in;
   logic [LIM_W-1:0]      plim_ff, mlim_ff, plim_in, mlim_in;
   logic                  pnz_ff, mnz_ff, pnz_in, mnz_in;
   // stage 4: decision
   logic                  v4_ff, v4_in;
   logic                  hit_ff, hit_in;
   logic [LIM_W-1:0]      inter_scaled;

   always_comb begin
      v1_in = in_valid;
      iw_in = span(max_c(motion.x_min, stored.x_min), min_c(motion.x_max, stored.x_max));
      ih_in = span(max_c(motion.y_min, stored.y_min), min_c(motion.y_max, stored.y_max));
      pw_in = span(stored.x_min, stored.x_max);
      ph_in = span(stored.y_min, stored.y_max);
      mw_in = span(motion.x_min, motion.x_max);
      mh_in = span(motion.y_min, motion.y_max);

      v2_in     = v1_ff;
      inter2_in = AREA_W'(iw_ff) * AREA_W'(ih_ff);
      parea_in  = AREA_W'(pw_ff) * AREA_W'(ph_ff);
      marea_in  = AREA_W'(mw_ff) * AREA_W'(mh_ff);

      v3_in     = v2_ff;
      inter3_in = inter2_ff;
      plim_in   = LIM_W'(threshold) * LIM_W'(parea_ff);
      mlim_in   = LIM_W'(threshold) * LIM_W'(marea_ff);
      pnz_in    = (parea_ff != '0);
      mnz_in    = (marea_ff != '0);

      inter_scaled = {inter3_ff, {THR_W{1'b0}}};
      v4_in  = v3_ff;
      hit_in = (pnz_ff && (inter_scaled > plim_ff)) || (mnz_ff && (inter_scaled > mlim_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   always_ff @(posedge clock) begin
      iw_ff     <= iw_in;
      ih_ff     <= ih_in;
      pw_ff     <= pw_in;
      ph_ff     <= ph_in;
      mw_ff     <= mw_in;
      mh_ff     <= mh_in;
      inter2_ff <= inter2_in;
      parea_ff  <= parea_in;
      marea_ff  <= marea_in;
      inter3_ff <= inter3_in;
      plim_ff   <= plim_in;
      mlim_ff   <= mlim_in;
      pnz_ff    <= pnz_in;
      mnz_ff    <= mnz_in;
      hit_ff    <= hit_in;
   end

   assign stat.busy      = v1_ff | v2_ff | v3_ff | v4_ff;
   assign stat.hit_valid = v4_ff;
   assign stat.hit       = hit_ff;

endmodule
